FILE: rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Sector base, in sixths of a turn, picked by which channel is the minimum
  localparam int HUE_BASE_RED_MIN   = 3;
  localparam int HUE_BASE_GREEN_MIN = 5;
  localparam int HUE_BASE_BLUE_MIN  = 1;

  // Sixths in one full turn
  localparam int HUE_SPAN = 6;

  // Control that travels with every pipeline stage
  typedef struct packed {
    logic valid;  // stage holds a transaction
    logic gray;   // max equals min: hue and saturation forced to zero
  } rhc_ctrl_t;

endpackage

FILE: rtl/core/rgb_to_hsv_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Pipelined RGB(A) to HSV(A) pixel converter, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_red/in_green/in_blue/in_alpha and raise start. A
//   transaction is taken on each rising edge with start high and busy low.
//   busy is always low: a new pixel may enter on every clock.
//   Output: out_strobe is high for exactly one cycle per pixel, with
//   out_hue (fraction of a turn), out_saturation (one integer bit plus
//   FRACTION_BITS fraction bits), out_brightness (channel max) and
//   out_alpha (copied). Results leave in input order.
//   Pipeline: one front stage for min/max and sector, FRACTION_BITS + 1
//   division steps producing one quotient bit each for hue and saturation
//   side by side, one output register. Throughput is one pixel per cycle;
//   the division pipeline depth sets the latency.
//   Reset (synchronous, rst_n low) clears every stage valid bit; pixels in
//   flight are dropped and no strobe follows.
//   The receiver cannot stall: each result shows for one cycle only.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit import rhc_pkg::*; #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [CHANNEL_BITS-1:0]   in_red,
  input  logic [CHANNEL_BITS-1:0]   in_green,
  input  logic [CHANNEL_BITS-1:0]   in_blue,
  input  logic [CHANNEL_BITS-1:0]   in_alpha,
  output logic                      out_strobe,
  output logic [FRACTION_BITS-1:0]  out_hue,
  output logic [FRACTION_BITS:0]    out_saturation,
  output logic [CHANNEL_BITS-1:0]   out_brightness,
  output logic [CHANNEL_BITS-1:0]   out_alpha
);

  localparam int HW = CHANNEL_BITS + 3;  // hue divisor = 6 * chroma
  localparam int QW = FRACTION_BITS + 1; // quotient bits per division

  // Stage k feeds division step k; index QW is the last step's output
  rhc_ctrl_t               ctrl_s    [0:QW];
  logic [HW-1:0]           hue_rem_s [0:QW];
  logic [HW-1:0]           hue_div_s [0:QW];
  logic [QW-1:0]           hue_quo_s [0:QW];
  logic [CHANNEL_BITS-1:0] sat_rem_s [0:QW];
  logic [CHANNEL_BITS-1:0] max_s     [0:QW];
  logic [QW-1:0]           sat_quo_s [0:QW];
  logic [CHANNEL_BITS-1:0] alpha_s   [0:QW];

  logic                    strobe_r;
  logic [FRACTION_BITS-1:0] hue_r;
  logic [QW-1:0]           sat_r;
  logic [CHANNEL_BITS-1:0] bright_r;
  logic [CHANNEL_BITS-1:0] alpha_r;

  // Fully pipelined: never refuses a transaction
  assign busy = 1'b0;

  // Front: min/max, chroma, sector and hue numerator
  rhc_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_i    (start),
    .red_i     (in_red),
    .green_i   (in_green),
    .blue_i    (in_blue),
    .alpha_i   (in_alpha),
    .ctrl_o    (ctrl_s[0]),
    .hue_num_o (hue_rem_s[0]),
    .hue_div_o (hue_div_s[0]),
    .chroma_o  (sat_rem_s[0]),
    .max_o     (max_s[0]),
    .alpha_o   (alpha_s[0])
  );

  assign hue_quo_s[0] = '0;
  assign sat_quo_s[0] = '0;

  // Division pipeline: one quotient bit per stage, MSB first.
  // Numerators never exceed their divisors, so QW bits hold the quotient.
  for (genvar k = 0; k < QW; k++) begin : g_div
    rhc_div_stage #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .FIRST         (k == 0)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl_s[k]),
      .hue_rem_i (hue_rem_s[k]),
      .hue_div_i (hue_div_s[k]),
      .hue_quo_i (hue_quo_s[k]),
      .sat_rem_i (sat_rem_s[k]),
      .max_i     (max_s[k]),
      .sat_quo_i (sat_quo_s[k]),
      .alpha_i   (alpha_s[k]),
      .ctrl_o    (ctrl_s[k+1]),
      .hue_rem_o (hue_rem_s[k+1]),
      .hue_div_o (hue_div_s[k+1]),
      .hue_quo_o (hue_quo_s[k+1]),
      .sat_rem_o (sat_rem_s[k+1]),
      .max_o     (max_s[k+1]),
      .sat_quo_o (sat_quo_s[k+1]),
      .alpha_o   (alpha_s[k+1])
    );
  end

  // Output register. A full-turn hue wraps to zero by dropping the top
  // quotient bit; gray pixels force hue and saturation to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctrl_s[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= ctrl_s[QW].gray ? '0 : hue_quo_s[QW][FRACTION_BITS-1:0];
    sat_r    <= ctrl_s[QW].gray ? '0 : sat_quo_s[QW];
    bright_r <= max_s[QW];
    alpha_r  <= alpha_s[QW];
  end

  assign out_strobe     = strobe_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;
  assign out_alpha      = alpha_r;

endmodule

FILE: rtl/core/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Front stage: channel min/max, chroma, sector choice and hue numerator.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take_i,
  input  logic [CHANNEL_BITS-1:0]   red_i,
  input  logic [CHANNEL_BITS-1:0]   green_i,
  input  logic [CHANNEL_BITS-1:0]   blue_i,
  input  logic [CHANNEL_BITS-1:0]   alpha_i,
  output rhc_ctrl_t                 ctrl_o,
  output logic [CHANNEL_BITS+2:0]   hue_num_o,
  output logic [CHANNEL_BITS+2:0]   hue_div_o,
  output logic [CHANNEL_BITS-1:0]   chroma_o,
  output logic [CHANNEL_BITS-1:0]   max_o,
  output logic [CHANNEL_BITS-1:0]   alpha_o
);

  localparam int HW = CHANNEL_BITS + 3;  // holds 6 * chroma
  localparam int SW = CHANNEL_BITS + 4;  // signed working width

  logic [CHANNEL_BITS-1:0] mn;
  logic [CHANNEL_BITS-1:0] mx;
  logic [CHANNEL_BITS-1:0] chroma;
  logic [SW-1:0]           base_term;
  logic [SW-1:0]           diff_term;
  logic [SW-1:0]           num_full;
  logic [SW-1:0]           div_full;

  rhc_ctrl_t               ctrl_r;
  logic [HW-1:0]           hue_num_r;
  logic [HW-1:0]           hue_div_r;
  logic [CHANNEL_BITS-1:0] chroma_r;
  logic [CHANNEL_BITS-1:0] max_r;
  logic [CHANNEL_BITS-1:0] alpha_r;

  always_comb begin
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) begin
      mn = blue_i;
    end
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) begin
      mx = blue_i;
    end
    chroma = mx - mn;

    // red tested first, then green
    if (red_i == mn) begin
      base_term = SW'(chroma) * SW'(HUE_BASE_RED_MIN);
      diff_term = SW'(green_i) - SW'(blue_i);
    end else if (green_i == mn) begin
      base_term = SW'(chroma) * SW'(HUE_BASE_GREEN_MIN);
      diff_term = SW'(blue_i) - SW'(red_i);
    end else begin
      base_term = SW'(chroma) * SW'(HUE_BASE_BLUE_MIN);
      diff_term = SW'(red_i) - SW'(green_i);
    end
    // lies in 0 .. 6*chroma
    num_full = base_term - diff_term;
    div_full = SW'(chroma) * SW'(HUE_SPAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r.valid <= take_i;
      ctrl_r.gray  <= (chroma == '0);
    end
  end

  always_ff @(posedge clk) begin
    hue_num_r <= num_full[HW-1:0];
    hue_div_r <= div_full[HW-1:0];
    chroma_r  <= chroma;
    max_r     <= mx;
    alpha_r   <= alpha_i;
  end

  assign ctrl_o    = ctrl_r;
  assign hue_num_o = hue_num_r;
  assign hue_div_o = hue_div_r;
  assign chroma_o  = chroma_r;
  assign max_o     = max_r;
  assign alpha_o   = alpha_r;

endmodule

FILE: rtl/core/rhc_div_stage.sv
// ----------------------------------------------------------------------------
// rhc_div_stage
// One registered restoring-division step for hue and saturation in parallel.
// The first step compares the raw numerator, later steps shift in a zero.
// ----------------------------------------------------------------------------
module rhc_div_stage import rhc_pkg::*; #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16,
  parameter bit FIRST         = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rhc_ctrl_t                 ctrl_i,
  input  logic [CHANNEL_BITS+2:0]   hue_rem_i,
  input  logic [CHANNEL_BITS+2:0]   hue_div_i,
  input  logic [FRACTION_BITS:0]    hue_quo_i,
  input  logic [CHANNEL_BITS-1:0]   sat_rem_i,
  input  logic [CHANNEL_BITS-1:0]   max_i,
  input  logic [FRACTION_BITS:0]    sat_quo_i,
  input  logic [CHANNEL_BITS-1:0]   alpha_i,
  output rhc_ctrl_t                 ctrl_o,
  output logic [CHANNEL_BITS+2:0]   hue_rem_o,
  output logic [CHANNEL_BITS+2:0]   hue_div_o,
  output logic [FRACTION_BITS:0]    hue_quo_o,
  output logic [CHANNEL_BITS-1:0]   sat_rem_o,
  output logic [CHANNEL_BITS-1:0]   max_o,
  output logic [FRACTION_BITS:0]    sat_quo_o,
  output logic [CHANNEL_BITS-1:0]   alpha_o
);

  localparam int HW = CHANNEL_BITS + 3;
  localparam int QW = FRACTION_BITS + 1;

  logic [HW:0]           hue_part;
  logic [HW:0]           hue_diff;
  logic                  hue_bit;
  logic [CHANNEL_BITS:0] sat_part;
  logic [CHANNEL_BITS:0] sat_diff;
  logic                  sat_bit;

  rhc_ctrl_t               ctrl_r;
  logic [HW-1:0]           hue_rem_r;
  logic [HW-1:0]           hue_div_r;
  logic [QW-1:0]           hue_quo_r;
  logic [CHANNEL_BITS-1:0] sat_rem_r;
  logic [CHANNEL_BITS-1:0] max_r;
  logic [QW-1:0]           sat_quo_r;
  logic [CHANNEL_BITS-1:0] alpha_r;

  always_comb begin
    if (FIRST) begin
      hue_part = {1'b0, hue_rem_i};
      sat_part = {1'b0, sat_rem_i};
    end else begin
      hue_part = {hue_rem_i, 1'b0};
      sat_part = {sat_rem_i, 1'b0};
    end
    hue_diff = hue_part - {1'b0, hue_div_i};
    hue_bit  = (hue_part >= {1'b0, hue_div_i});
    sat_diff = sat_part - {1'b0, max_i};
    sat_bit  = (sat_part >= {1'b0, max_i});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  // remainder stays below the divisor, so the top bit drops cleanly
  always_ff @(posedge clk) begin
    hue_rem_r <= hue_bit ? hue_diff[HW-1:0] : hue_part[HW-1:0];
    hue_div_r <= hue_div_i;
    hue_quo_r <= {hue_quo_i[QW-2:0], hue_bit};
    sat_rem_r <= sat_bit ? sat_diff[CHANNEL_BITS-1:0] : sat_part[CHANNEL_BITS-1:0];
    max_r     <= max_i;
    sat_quo_r <= {sat_quo_i[QW-2:0], sat_bit};
    alpha_r   <= alpha_i;
  end

  assign ctrl_o    = ctrl_r;
  assign hue_rem_o = hue_rem_r;
  assign hue_div_o = hue_div_r;
  assign hue_quo_o = hue_quo_r;
  assign sat_rem_o = sat_rem_r;
  assign max_o     = max_r;
  assign sat_quo_o = sat_quo_r;
  assign alpha_o   = alpha_r;

endmodule
